@@ hdl/iceps_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ICMP echo probe statistics - shared definitions
// Types, codes and constants used by the controller, datapath and top level.
// ---------------------------------------------------------------------------
package iceps_pkg;

   localparam int unsigned MIN_REPLY_LEN   = 76;
   localparam int unsigned TIMEOUT_RESET   = 1000;
   localparam int unsigned SUM_WIDTH       = 48;
   localparam int unsigned DIV_STEPS       = SUM_WIDTH;
   localparam int unsigned DIV_CNT_WIDTH   = $clog2(DIV_STEPS);
   localparam logic [15:0] REPLIES_MAX     = 16'hFFFF;
   localparam int unsigned REQ_DATA_WIDTH  = 136;
   localparam int unsigned RSP_DATA_WIDTH  = 216;

   typedef enum logic [1:0] {
      ACT_TIME   = 2'd0,
      ACT_PACKET = 2'd1,
      ACT_START  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_TARGET  = 2'd0,
      REG_COUNT   = 2'd1,
      REG_TIMEOUT = 2'd2,
      REG_SPARE   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PROBE = 2'd1,
      PH_FINAL = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] now_ms;
      logic [31:0] from_addr;
      logic [15:0] packet_length;
      logic [7:0]  icmp_kind;
      logic [15:0] echoed_seq;
      logic [31:0] echoed_stamp_ms;
   } req_item_type;

   typedef struct packed {
      logic        send_probe;
      logic [15:0] probe_seq;
      logic        reply_counted;
      logic [15:0] reply_seq;
      logic [15:0] reply_length;
      logic [31:0] trip_ms;
      logic [15:0] success_count;
      logic [15:0] fail_count;
      logic [31:0] avg_trip_ms;
      logic [31:0] min_trip_ms;
      logic [31:0] max_trip_ms;
      logic        done_res;
   } rsp_item_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic div_step;
      logic div_last;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      logic reply_hit;
   } ctl_stat_type;

endpackage

@@ hdl/iceps_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ICMP echo probe statistics - controller
// Sequences item capture, update, the average division and the result
// register hand-off.
// ---------------------------------------------------------------------------
module iceps_ctrl
   import iceps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output ctl_cmd_type  cmd,
   input  ctl_stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     valid_ff, valid_in;
   logic                     out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cnt_in   = '0;
            state_in = stat.reply_hit ? ST_DIV : ST_WRITE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ hdl/iceps_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ICMP echo probe statistics - datapath
// Configuration, run state, statistics, restoring divider for the average
// and the result register.
// ---------------------------------------------------------------------------
module iceps_dp
   import iceps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata,
   input  req_item_type  req_item,
   input  ctl_cmd_type   cmd,
   output ctl_stat_type  stat,
   output rsp_item_type  rsp_item
);

   logic [31:0]          target_ff, target_in;
   logic [15:0]          count_ff, count_in;
   logic [15:0]          timeout_ff, timeout_in;

   req_item_type         item_ff, item_in;

   phase_type            phase_ff, phase_in;
   logic [15:0]          left_ff, left_in;
   logic [31:0]          deadline_ff, deadline_in;
   logic [15:0]          sent_ff, sent_in;
   logic [15:0]          replies_ff, replies_in;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [31:0]          avg_ff, avg_in;
   logic [31:0]          min_ff, min_in;
   logic [31:0]          max_ff, max_in;

   logic                 send_ff, send_in;
   logic [15:0]          pseq_ff, pseq_in;
   logic                 counted_ff, counted_in;
   logic [15:0]          rseq_ff, rseq_in;
   logic [15:0]          rlen_ff, rlen_in;
   logic [31:0]          trip_ff, trip_in;

   logic [15:0]          rem_ff, rem_in;
   logic [SUM_WIDTH-1:0] quo_ff, quo_in;

   rsp_item_type         out_ff, out_in;

   logic [31:0]          trip;
   logic                 hit;
   logic                 in_run;
   logic [16:0]          trial;
   logic [16:0]          shifted;

   assign trip   = item_ff.now_ms - item_ff.echoed_stamp_ms;
   assign in_run = (phase_ff == PH_PROBE) || (phase_ff == PH_FINAL);
   assign hit    = (item_ff.action == ACT_PACKET) && in_run
                   && (item_ff.from_addr == target_ff)
                   && (item_ff.packet_length >= 16'(MIN_REPLY_LEN))
                   && (item_ff.icmp_kind == 8'd0);

   assign stat.reply_hit = hit;
   assign rsp_item       = out_ff;

   // one quotient bit per step
   assign shifted = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign trial   = shifted - {1'b0, replies_ff};

   always_comb begin
      target_in  = target_ff;
      count_in   = count_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TARGET:  target_in  = csr_wdata;
            REG_COUNT:   count_in   = csr_wdata[15:0];
            REG_TIMEOUT: timeout_in = csr_wdata[15:0];
            REG_SPARE:   ;
            default:     ;
         endcase
      end
   end

   assign item_in = cmd.load_item ? req_item : item_ff;

   always_comb begin
      phase_in    = phase_ff;
      left_in     = left_ff;
      deadline_in = deadline_ff;
      sent_in     = sent_ff;
      replies_in  = replies_ff;
      sum_in      = sum_ff;
      avg_in      = avg_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      send_in     = send_ff;
      pseq_in     = pseq_ff;
      counted_in  = counted_ff;
      rseq_in     = rseq_ff;
      rlen_in     = rlen_ff;
      trip_in     = trip_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;

      if (cmd.exec) begin
         send_in    = 1'b0;
         pseq_in    = '0;
         counted_in = 1'b0;
         rseq_in    = '0;
         rlen_in    = '0;
         trip_in    = '0;
         unique case (item_ff.action)
            ACT_START: begin
               left_in     = count_ff;
               deadline_in = item_ff.now_ms;
               sent_in     = '0;
               replies_in  = '0;
               sum_in      = '0;
               avg_in      = '0;
               min_in      = '0;
               max_in      = '0;
               phase_in    = (count_ff != 16'd0) ? PH_PROBE : PH_DONE;
            end
            ACT_TIME: begin
               if (phase_ff == PH_PROBE && deadline_ff < item_ff.now_ms
                   && left_ff != 16'd0) begin
                  sent_in     = sent_ff + 16'd1;
                  send_in     = 1'b1;
                  pseq_in     = sent_ff + 16'd1;
                  deadline_in = item_ff.now_ms + {16'd0, timeout_ff};
                  left_in     = left_ff - 16'd1;
                  if (left_ff == 16'd1) begin
                     phase_in = PH_FINAL;
                  end
               end else if (phase_ff == PH_FINAL && deadline_ff < item_ff.now_ms) begin
                  phase_in = PH_DONE;
               end
            end
            ACT_PACKET: begin
               if (hit) begin
                  counted_in = 1'b1;
                  rseq_in    = item_ff.echoed_seq;
                  rlen_in    = item_ff.packet_length;
                  trip_in    = trip;
                  if (replies_ff != REPLIES_MAX) begin
                     replies_in = replies_ff + 16'd1;
                  end
                  sum_in = sum_ff + {{(SUM_WIDTH-32){1'b0}}, trip};
                  if (min_ff == 32'd0 || trip < min_ff) begin
                     min_in = trip;
                  end
                  if (trip > max_ff) begin
                     max_in = trip;
                  end
                  rem_in = '0;
                  quo_in = sum_in;
               end
               if (phase_ff == PH_FINAL) begin
                  phase_in = PH_DONE;
               end
            end
            ACT_NONE: ;
            default:  ;
         endcase
      end

      if (cmd.div_step) begin
         if (!trial[16]) begin
            rem_in = trial[15:0];
         end else begin
            rem_in = shifted[15:0];
         end
         quo_in = {quo_ff[SUM_WIDTH-2:0], !trial[16]};
         if (cmd.div_last) begin
            avg_in = quo_in[31:0];
         end
      end
   end

   always_comb begin
      out_in = out_ff;
      if (cmd.load_out) begin
         out_in.send_probe    = send_ff;
         out_in.probe_seq     = pseq_ff;
         out_in.reply_counted = counted_ff;
         out_in.reply_seq     = rseq_ff;
         out_in.reply_length  = rlen_ff;
         out_in.trip_ms       = trip_ff;
         out_in.success_count = replies_ff;
         out_in.fail_count    = sent_ff - replies_ff;
         out_in.avg_trip_ms   = avg_ff;
         out_in.min_trip_ms   = min_ff;
         out_in.max_trip_ms   = max_ff;
         out_in.done_res      = (phase_ff == PH_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         count_ff    <= '0;
         timeout_ff  <= 16'(TIMEOUT_RESET);
         phase_ff    <= PH_IDLE;
         left_ff     <= '0;
         deadline_ff <= '0;
         sent_ff     <= '0;
         replies_ff  <= '0;
         sum_ff      <= '0;
         avg_ff      <= '0;
         min_ff      <= '0;
         max_ff      <= '0;
      end else begin
         target_ff   <= target_in;
         count_ff    <= count_in;
         timeout_ff  <= timeout_in;
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         deadline_ff <= deadline_in;
         sent_ff     <= sent_in;
         replies_ff  <= replies_in;
         sum_ff      <= sum_in;
         avg_ff      <= avg_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      send_ff    <= send_in;
      pseq_ff    <= pseq_in;
      counted_ff <= counted_in;
      rseq_ff    <= rseq_in;
      rlen_ff    <= rlen_in;
      trip_ff    <= trip_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      out_ff     <= out_in;
   end

endmodule

@@ hdl/icmp_echo_probe_statistics_top.sv @@
`timescale 1ns / 1ps
// Sequence: an item is captured and updated, a counted reply then has its
//   average taken by a 48-step restoring divider, and the result is loaded.
// Flow: one item at a time, the next taken once the last result is loaded,
//   which waits for a free output register; a result waits there meanwhile.
// Reset: synchronous, clears run state, statistics and the result register
//   valid; the timeout register returns to 1000 ms.
// ---------------------------------------------------------------------------
// ICMP echo probe statistics - top level
// Echo probe sequencer with round-trip statistics on stream channels.
// ---------------------------------------------------------------------------
module icmp_echo_probe_statistics_top
   import iceps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // now_ms, from_addr, packet_length, icmp_kind, echoed_seq, echoed_stamp_ms
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // action
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // send_probe, probe_seq, reply_counted, reply_seq, reply_length, trip_ms,
   // success_count, fail_count, avg_trip_ms, min_trip_ms, max_trip_ms,
   // done_res, zero padding
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   req_item_type req_item;
   rsp_item_type rsp_item;

   assign req_item.action          = action_type'(req_tuser);
   assign req_item.now_ms          = req_tdata[31:0];
   assign req_item.from_addr       = req_tdata[63:32];
   assign req_item.packet_length   = req_tdata[79:64];
   assign req_item.icmp_kind       = req_tdata[87:80];
   assign req_item.echoed_seq      = req_tdata[103:88];
   assign req_item.echoed_stamp_ms = req_tdata[135:104];

   assign rsp_tdata = {5'd0,
                       rsp_item.done_res,
                       rsp_item.max_trip_ms,
                       rsp_item.min_trip_ms,
                       rsp_item.avg_trip_ms,
                       rsp_item.fail_count,
                       rsp_item.success_count,
                       rsp_item.trip_ms,
                       rsp_item.reply_length,
                       rsp_item.reply_seq,
                       rsp_item.reply_counted,
                       rsp_item.probe_seq,
                       rsp_item.send_probe};

   iceps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   iceps_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_item  (rsp_item)
   );

endmodule

@@ hdl/iceps_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ICMP echo probe statistics - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
module iceps_checker
   import iceps_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   a_reply_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tdata[49:34] >= 16'(MIN_REPLY_LEN))
      else $error("short reply counted");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[177:146] <= rsp_tdata[209:178])
      else $error("minimum trip above maximum");

endmodule

bind icmp_echo_probe_statistics_top iceps_checker u_iceps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
